FILE: rtl/nsme_pkg.sv
// Shared types, constants and lookup functions for the score-to-event block.
`timescale 1ns / 1ps
package nsme_pkg;

  localparam int TimeW = 48;
  localparam int InfoW = 26;
  localparam logic [1:0] KIND_TEMPO = 2'd0;
  localparam logic [1:0] KIND_TRANSPOSE = 2'd1;
  localparam logic [1:0] KIND_OFF = 2'd2;
  localparam logic [1:0] KIND_ON = 2'd3;
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_TOKEN = 2'd1;
  localparam logic [1:0] ERR_FULL = 2'd2;
  localparam logic [7:0] MiddleC = 8'sd60;
  localparam logic [7:0] KeyMax = 8'd127;
  localparam logic [14:0] BeatReset = 15'd1000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_STORE, ST_STORE2, ST_FILL, ST_SCAN_RD, ST_SCAN, ST_EMIT, ST_WAIT,
    ST_ERR
  } nsme_state_t;

  typedef struct packed {
    logic       load;
    logic       do_mul;
    logic       wr_first;
    logic       wr_second;
    logic       scan_start;
    logic       scan_rd;
    logic       scan_step;
    logic       emit_load;
    logic       emit_err;
    logic       finish;
  } nsme_cmd_t;

  typedef struct packed {
    logic       has_event;
    logic       two_events;
    logic       is_last;
    logic       err_set;
    logic       empty;
    logic       scan_done;
    logic       all_sent;
  } nsme_stat_t;

  function automatic logic [4:0] degree_semis(input logic [2:0] d);
    logic [4:0] r;
    case (d)
      3'd0: r = 5'd0;
      3'd1: r = 5'd2;
      3'd2: r = 5'd4;
      3'd3: r = 5'd5;
      3'd4: r = 5'd7;
      3'd5: r = 5'd9;
      3'd6: r = 5'd11;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] prio(input logic [1:0] k);
    return (k == KIND_ON) ? 2'd2 : ((k == KIND_OFF) ? 2'd1 : 2'd0);
  endfunction

endpackage

FILE: rtl/numbered_score_to_midi_events.sv
// Top level of the numbered-score to MIDI event scheduler.
// Each word passes MUL, STORE, STORE2 (notes), FILL; in_ready is low meanwhile.
// Output: per result the scan reads every stored event and waits for out_ready.
// The event store has one read port; the selection scan walks it per result.
// Reset is synchronous active low and clears the score state and controller.
`timescale 1ns / 1ps
module numbered_score_to_midi_events #(
  parameter int MAX_EVENTS = 64,
  parameter int MAX_TOKEN_CHARS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_initial_beat_ms,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        in_token_chars,
  input  logic [3:0]         in_token_length,
  input  logic [31:0]        in_begin_beats,
  input  logic [31:0]        in_length_beats,
  input  logic signed [15:0] in_command_value,
  input  logic               in_last_command,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [47:0]        out_event_time_ms,
  output logic [1:0]         out_event_kind,
  output logic signed [7:0]  out_note_key,
  output logic signed [15:0] out_event_amount,
  output logic               out_event_present,
  output logic [1:0]         out_error_code,
  output logic               out_last_result
);
  import nsme_pkg::*;
  logic [14:0] cfg_r;
  nsme_cmd_t cmd;
  nsme_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= BeatReset;
    else if (cfg_we) cfg_r <= cfg_initial_beat_ms;
  end

  nsme_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  nsme_datapath #(.MAX_EVENTS(MAX_EVENTS), .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .cfg_beat(cfg_r),
    .in_token_chars, .in_token_length, .in_begin_beats, .in_length_beats,
    .in_command_value, .in_last_command,
    .out_event_time_ms, .out_event_kind, .out_note_key, .out_event_amount,
    .out_event_present, .out_error_code, .out_last_result
  );

endmodule

FILE: rtl/nsme_datapath.sv
// Datapath: token decode, time multiply, event store and selection sort output.
`timescale 1ns / 1ps
module nsme_datapath #(
  parameter int MAX_EVENTS = 64,
  parameter int MAX_TOKEN_CHARS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nsme_pkg::nsme_cmd_t  cmd,
  output nsme_pkg::nsme_stat_t stat,
  input  logic [14:0]          cfg_beat,
  input  logic [63:0]          in_token_chars,
  input  logic [3:0]           in_token_length,
  input  logic [31:0]          in_begin_beats,
  input  logic [31:0]          in_length_beats,
  input  logic signed [15:0]   in_command_value,
  input  logic                 in_last_command,
  output logic [47:0]          out_event_time_ms,
  output logic [1:0]           out_event_kind,
  output logic signed [7:0]    out_note_key,
  output logic signed [15:0]   out_event_amount,
  output logic                 out_event_present,
  output logic [1:0]           out_error_code,
  output logic                 out_last_result
);
  import nsme_pkg::*;
  localparam int IW = $clog2(MAX_EVENTS);
  localparam int CW = $clog2(MAX_EVENTS + 1);

  logic [14:0] beat_r, beat_nxt;
  logic signed [3:0] tr_r;
  logic [1:0] err_r;
  logic [CW-1:0] cnt_r;
  logic [7:0] ch [8];
  logic [3:0] len;
  logic [31:0] beg_r, lenb_r;
  logic last_r;
  logic [1:0] kind_r;
  logic signed [7:0] key_r;
  logic signed [15:0] amt_r;
  logic has_r, two_r, bad_r, newtr_r, newbeat_r;
  logic signed [3:0] trv_r;
  logic [47:0] t_on_r, t_len_r;
  logic [47:0] tmem [MAX_EVENTS];
  logic [InfoW-1:0] imem [MAX_EVENTS];
  logic [MAX_EVENTS-1:0] sent_r;
  logic [IW-1:0] ri_r, best_r;
  logic [CW-1:0] cnt_out_r;
  logic best_ok_r;
  logic [47:0] best_t_r, rd_t_r;
  logic [InfoW-1:0] best_f_r, rd_f_r;
  logic [IW-1:0] rd_i_r;
  logic [CW-1:0] emitted_r;

  // Decode of the current word.
  logic d_rest, d_tempo, d_keyok, d_noteok;
  logic signed [4:0] d_tr;
  logic signed [8:0] d_raw;
  logic signed [15:0] d_vel;
  logic signed [4:0] oct;
  logic acc, stop;
  logic [3:0] pos;
  logic minus, plus;
  logic [2:0] li;
  always_comb begin
    for (int i = 0; i < 8; i++) ch[i] = in_token_chars[8*i +: 8];
    len = (in_token_length > 4'(MAX_TOKEN_CHARS)) ? 4'(MAX_TOKEN_CHARS) : in_token_length;
    d_rest = (len == 4'd0) || (ch[0] == "0");
    d_tempo = (len == 4'd1) && (ch[0] == "S");
    minus = (len == 4'd2) && (ch[1] == "-");
    plus = (len == 4'd2) && (ch[1] == "+");
    d_keyok = 1'b0;
    d_tr = '0;
    li = 3'(ch[0] - "A");
    if ((len == 4'd1 || minus || plus) && ch[0] >= "A" && ch[0] <= "G") begin
      d_keyok = 1'b1;
      case (li)
        3'd0: d_tr = minus ? -5'sd4 : -5'sd3;
        3'd1: d_tr = minus ? -5'sd2 : -5'sd1;
        3'd2: d_tr = 5'sd0;
        3'd3: d_tr = minus ? 5'sd1 : 5'sd2;
        3'd4: d_tr = minus ? 5'sd3 : 5'sd4;
        3'd5: d_tr = 5'sd5;
        default: d_tr = minus ? -5'sd6 : -5'sd5;
      endcase
    end else if ((len == 4'd1 || minus || plus) && ch[0] >= "a" && ch[0] <= "g") begin
      d_keyok = 1'b1;
      li = 3'(ch[0] - "a");
      case (li)
        3'd0: d_tr = 5'sd0;
        3'd1: d_tr = minus ? 5'sd1 : 5'sd2;
        3'd2: d_tr = plus ? 5'sd4 : 5'sd3;
        3'd3: d_tr = 5'sd5;
        3'd4: d_tr = minus ? -5'sd6 : -5'sd5;
        3'd5: d_tr = plus ? -5'sd3 : -5'sd4;
        default: d_tr = plus ? -5'sd1 : -5'sd2;
      endcase
    end
    acc = (len > 4'd1) && (ch[1] == "#");
    pos = acc ? 4'd2 : 4'd1;
    oct = '0;
    stop = 1'b0;
    for (int i = 1; i < 8; i++) begin
      if (4'(i) >= pos && 4'(i) < len && !stop) begin
        if (ch[i] == "+") oct = oct + 5'sd1;
        else if (ch[i] == "-") oct = oct - 5'sd1;
        else stop = 1'b1;
      end
    end
    d_noteok = (len != 4'd0) && ch[0] >= "1" && ch[0] <= "7" && !stop;
    d_raw = 9'sd60 + 9'(tr_r) + 9'(signed'({1'b0, degree_semis(3'(ch[0] - "1"))}))
          + 9'(signed'({1'b0, acc})) + 9'(oct) * 9'sd12;
    d_vel = (in_command_value < 16'sd1) ? 16'sd1
          : ((in_command_value > 16'sd127) ? 16'sd127 : in_command_value);
  end

  // Per-word command registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      beg_r <= in_begin_beats;
      lenb_r <= in_length_beats;
      last_r <= in_last_command;
      has_r <= 1'b0;
      two_r <= 1'b0;
      bad_r <= 1'b0;
      newtr_r <= 1'b0;
      newbeat_r <= 1'b0;
      trv_r <= 4'(d_tr);
      if (err_r == ERR_NONE && !(len == 4'd0)) begin
        if (d_tempo) begin
          has_r <= 1'b1;
          kind_r <= KIND_TEMPO;
          key_r <= -8'sd1;
          newbeat_r <= (in_command_value > 16'sd0);
          amt_r <= (in_command_value > 16'sd0) ? {1'b0, in_command_value[14:0]}
                                              : {1'b0, beat_r};
        end else if (d_rest) begin
        end else if (d_keyok) begin
          has_r <= 1'b1;
          newtr_r <= 1'b1;
          kind_r <= KIND_TRANSPOSE;
          key_r <= -8'sd1;
          amt_r <= 16'(d_tr);
        end else if (d_noteok) begin
          has_r <= 1'b1;
          two_r <= 1'b1;
          kind_r <= KIND_ON;
          key_r <= (d_raw < 9'sd0) ? 8'sd0 : ((d_raw > 9'sd127) ? 8'sd127 : 8'(d_raw));
          amt_r <= d_vel;
        end else begin
          bad_r <= 1'b1;
        end
      end
    end
    if (cmd.do_mul) begin
      t_on_r <= 48'(beg_r) * 48'(beat_r);
      t_len_r <= 48'(lenb_r) * 48'(beat_r);
    end
  end

  assign stat.has_event = has_r;
  assign stat.two_events = two_r;
  assign stat.is_last = last_r;
  assign stat.err_set = (err_r != ERR_NONE);
  assign stat.empty = (cnt_r == '0);

  logic full1, full2;
  assign full1 = (cnt_r >= CW'(MAX_EVENTS));
  assign full2 = (cnt_r >= CW'(MAX_EVENTS - 1));

  // Score state.
  always_comb begin
    beat_nxt = beat_r;
    if (cmd.wr_first && newbeat_r && !full1) beat_nxt = amt_r[14:0];
    if (cmd.finish) beat_nxt = cfg_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= BeatReset;
      tr_r <= '0;
      err_r <= ERR_NONE;
      cnt_r <= '0;
    end else begin
      beat_r <= beat_nxt;
      if (cmd.wr_first) begin
        if (bad_r) err_r <= ERR_TOKEN;
        else if (has_r && (two_r ? full2 : full1)) err_r <= ERR_FULL;
        else if (has_r) begin
          cnt_r <= cnt_r + CW'(1);
          if (newtr_r) tr_r <= trv_r;
        end
      end
      if (cmd.wr_second && err_r == ERR_NONE) cnt_r <= cnt_r + CW'(1);
      if (cmd.finish) begin
        tr_r <= '0;
        err_r <= ERR_NONE;
        cnt_r <= '0;
      end
    end
  end

  logic [IW-1:0] wa;
  assign wa = cnt_r[IW-1:0];
  always_ff @(posedge clk) begin
    if (cmd.wr_first && has_r && !bad_r && !(two_r ? full2 : full1)) begin
      tmem[wa] <= t_on_r;
      imem[wa] <= {amt_r, key_r, kind_r};
    end else if (cmd.wr_second && err_r == ERR_NONE) begin
      tmem[wa] <= t_on_r + t_len_r;
      imem[wa] <= {16'd0, key_r, KIND_OFF};
    end
  end

  // Pick the smallest unsent entry; ties go to lower prio(), then lowest index.
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_t_r <= tmem[ri_r];
      rd_f_r <= imem[ri_r];
      rd_i_r <= ri_r;
    end
  end

  logic better;
  assign better = !sent_r[rd_i_r] && (!best_ok_r || rd_t_r < best_t_r ||
                  (rd_t_r == best_t_r && prio(rd_f_r[1:0]) < prio(best_f_r[1:0])));
  assign stat.scan_done = (CW'(ri_r) + CW'(1) >= cnt_out_r);
  assign stat.all_sent = (emitted_r >= cnt_out_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r <= '0;
      ri_r <= '0;
      best_ok_r <= 1'b0;
      emitted_r <= '0;
      cnt_out_r <= '0;
    end else begin
      if (cmd.scan_start) begin
        sent_r <= '0;
        emitted_r <= '0;
        cnt_out_r <= cnt_r;
        ri_r <= '0;
        best_ok_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (better) begin
          best_ok_r <= 1'b1;
          best_t_r <= rd_t_r;
          best_f_r <= rd_f_r;
          best_r <= rd_i_r;
        end
        ri_r <= ri_r + IW'(1);
      end
      if (cmd.emit_load) begin
        sent_r[best_r] <= 1'b1;
        emitted_r <= emitted_r + CW'(1);
        ri_r <= '0;
        best_ok_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_event_time_ms <= best_t_r;
      out_event_kind <= best_f_r[1:0];
      out_note_key <= best_f_r[9:2];
      out_event_amount <= best_f_r[25:10];
      out_event_present <= 1'b1;
      out_error_code <= ERR_NONE;
      out_last_result <= (emitted_r + CW'(1) == cnt_out_r);
    end else if (cmd.emit_err) begin
      out_event_time_ms <= '0;
      out_event_kind <= '0;
      out_note_key <= '0;
      out_event_amount <= '0;
      out_event_present <= 1'b0;
      out_error_code <= err_r;
      out_last_result <= 1'b1;
    end
  end

endmodule

FILE: rtl/nsme_ctrl.sv
// Controller state machine sequencing accept, store, sort and emit.
`timescale 1ns / 1ps
module nsme_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  nsme_pkg::nsme_stat_t stat,
  output nsme_pkg::nsme_cmd_t  cmd
);
  import nsme_pkg::*;
  nsme_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_STORE;
      ST_STORE: begin
        if (stat.has_event && stat.two_events && !stat.err_set) state_nxt = ST_STORE2;
        else state_nxt = ST_FILL;
      end
      ST_STORE2: state_nxt = ST_FILL;
      ST_FILL: begin
        if (!stat.is_last) state_nxt = ST_IDLE;
        else if (stat.err_set || stat.empty) state_nxt = ST_ERR;
        else state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: state_nxt = ST_SCAN;
      ST_SCAN: state_nxt = stat.scan_done ? ST_EMIT : ST_SCAN_RD;
      ST_EMIT: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (out_ready) state_nxt = stat.all_sent ? ST_IDLE : ST_SCAN_RD;
      end
      ST_ERR: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state_r == ST_IDLE);
    out_valid = (state_r == ST_WAIT) || (state_r == ST_ERR);
    cmd.load = in_ready && in_valid;
    cmd.do_mul = (state_r == ST_MUL);
    cmd.wr_first = (state_r == ST_STORE);
    cmd.wr_second = (state_r == ST_STORE2);
    cmd.scan_start = (state_r == ST_FILL) && stat.is_last;
    cmd.emit_err = (state_r == ST_FILL) && stat.is_last && (stat.err_set || stat.empty);
    cmd.scan_rd = (state_r == ST_SCAN_RD);
    cmd.scan_step = (state_r == ST_SCAN);
    cmd.emit_load = (state_r == ST_EMIT);
    cmd.finish = ((state_r == ST_WAIT) && out_ready && stat.all_sent) ||
                 ((state_r == ST_ERR) && out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_rdy_out: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("ready while output pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
  a_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.do_mul) else $error("multiply not issued");
`endif

endmodule

FILE: verif/score_event_checker.sv
// Checker that predicts and compares the MIDI events of the score-to-event block.
`timescale 1ns / 1ps
module score_event_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_initial_beat_ms,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [63:0]        in_token_chars,
  input  logic [3:0]         in_token_length,
  input  logic [31:0]        in_begin_beats,
  input  logic [31:0]        in_length_beats,
  input  logic signed [15:0] in_command_value,
  input  logic               in_last_command,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [47:0]        out_event_time_ms,
  input  logic [1:0]         out_event_kind,
  input  logic signed [7:0]  out_note_key,
  input  logic signed [15:0] out_event_amount,
  input  logic               out_event_present,
  input  logic [1:0]         out_error_code,
  input  logic               out_last_result,
  output int                 fails,
  output int                 outstanding
);
  import nsme_pkg::*;

  localparam int StoreDepth = 64;
  localparam int TokenMax = 8;
  localparam int NoteBase = 60;
  localparam int VelMax = 127;
  localparam int Octave = 12;
  localparam int Deg[7] = '{0, 2, 4, 5, 7, 9, 11};
  localparam int UpBase[7] = '{-3, -1, 0, 2, 4, 5, -5};
  localparam int UpMinus[7] = '{1, 1, 0, 1, 1, 0, 1};
  localparam int LoBase[7] = '{0, 2, 3, 5, -5, -4, -2};
  localparam int LoMinus[7] = '{0, 1, 0, 0, 1, 0, 0};
  localparam int LoPlus[7] = '{0, 0, 1, 0, 0, 1, 1};

  typedef struct {
    logic [47:0]        t;
    logic [1:0]         kind;
    logic signed [7:0]  key;
    logic signed [15:0] amt;
    logic               present;
    logic [1:0]         err;
    logic               last;
  } midi_event_t;

  midi_event_t        pending_events[$];
  logic [14:0]        start_beat;
  logic [14:0]        beat;
  int                 transpose;
  logic [1:0]         score_err;
  int                 stored;
  logic [47:0]        st_time[StoreDepth];
  logic [1:0]         st_kind[StoreDepth];
  logic signed [7:0]  st_key[StoreDepth];
  logic signed [15:0] st_amt[StoreDepth];

  assign outstanding = pending_events.size();

  initial fails = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  task automatic open_score();
    beat = start_beat;
    transpose = 0;
    score_err = ERR_NONE;
    stored = 0;
  endtask

  task automatic store_event(input logic [47:0] t, input logic [1:0] kind, input int key,
                             input int amt);
    if (stored < StoreDepth) begin
      st_time[stored] = t;
      st_kind[stored] = kind;
      st_key[stored] = 8'(key);
      st_amt[stored] = 16'(amt);
      stored++;
    end
  endtask

  function automatic int rank_of(input logic [1:0] kind);
    return (kind == KIND_ON) ? 2 : ((kind == KIND_OFF) ? 1 : 0);
  endfunction

  task automatic parse_word(input logic [63:0] ch, input logic [3:0] len_in,
                            input logic [31:0] bg, input logic [31:0] dur, input int val);
    byte unsigned c[8];
    int           len;
    int           pos;
    int           acc;
    int           oct;
    int           raw;
    int           trv;
    int           idx;
    bit           is_key;
    bit           minus;
    bit           plus;
    logic [47:0]  at;
    for (int i = 0; i < 8; i++) c[i] = ch[8*i +: 8];
    len = (len_in > TokenMax) ? TokenMax : len_in;
    at = 48'(bg) * 48'(beat);
    if (len == 0) return;
    if (len == 1 && c[0] == "S") begin
      if (stored + 1 > StoreDepth) begin
        score_err = ERR_FULL;
        return;
      end
      if (val > 0) beat = val[14:0];
      store_event(at, KIND_TEMPO, -1, int'(beat));
      return;
    end
    if (c[0] == "0") return;
    is_key = 0;
    trv = 0;
    if (len <= 2 && (len == 1 || c[1] == "+" || c[1] == "-")) begin
      minus = len == 2 && c[1] == "-";
      plus = len == 2 && c[1] == "+";
      if (c[0] >= "A" && c[0] <= "G") begin
        idx = c[0] - "A";
        trv = UpBase[idx] - ((minus && UpMinus[idx] != 0) ? 1 : 0);
        is_key = 1;
      end else if (c[0] >= "a" && c[0] <= "g") begin
        idx = c[0] - "a";
        trv = LoBase[idx] - ((minus && LoMinus[idx] != 0) ? 1 : 0)
              + ((plus && LoPlus[idx] != 0) ? 1 : 0);
        is_key = 1;
      end
    end
    if (is_key) begin
      if (stored + 1 > StoreDepth) begin
        score_err = ERR_FULL;
        return;
      end
      transpose = trv;
      store_event(at, KIND_TRANSPOSE, -1, trv);
      return;
    end
    if (c[0] < "1" || c[0] > "7") begin
      score_err = ERR_TOKEN;
      return;
    end
    pos = 1;
    acc = 0;
    oct = 0;
    if (pos < len && c[pos] == "#") begin
      acc = 1;
      pos++;
    end
    while (pos < len && (c[pos] == "+" || c[pos] == "-")) begin
      oct += (c[pos] == "+") ? 1 : -1;
      pos++;
    end
    if (pos != len) begin
      score_err = ERR_TOKEN;
      return;
    end
    raw = NoteBase + transpose + Deg[c[0] - "1"] + acc + oct * Octave;
    raw = (raw < 0) ? 0 : ((raw > VelMax) ? VelMax : raw);
    if (stored + 2 > StoreDepth) begin
      score_err = ERR_FULL;
      return;
    end
    store_event(at, KIND_ON, raw, (val < 1) ? 1 : ((val > VelMax) ? VelMax : val));
    store_event(at + 48'(dur) * 48'(beat), KIND_OFF, raw, 0);
  endtask

  task automatic flush_score();
    int          ord[StoreDepth];
    int          j;
    midi_event_t e;
    if (score_err != ERR_NONE || stored == 0) begin
      e = '{t: '0, kind: '0, key: '0, amt: '0, present: 0, err: score_err, last: 1};
      pending_events.insert(pending_events.size(), e);
    end else begin
      for (int i = 0; i < stored; i++) begin
        j = i;
        while (j > 0 && (st_time[ord[j-1]] > st_time[i] ||
               (st_time[ord[j-1]] == st_time[i] &&
                rank_of(st_kind[ord[j-1]]) > rank_of(st_kind[i])))) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = i;
      end
      for (int i = 0; i < stored; i++) begin
        e.t = st_time[ord[i]];
        e.kind = st_kind[ord[i]];
        e.key = st_key[ord[i]];
        e.amt = st_amt[ord[i]];
        e.present = 1;
        e.err = ERR_NONE;
        e.last = (i == stored - 1);
        pending_events.insert(pending_events.size(), e);
      end
    end
    open_score();
  endtask

  always @(posedge clk) begin
    midi_event_t want;
    if (!rst_n) begin
      start_beat = 15'd1000;
      open_score();
      pending_events.delete();
    end else begin
      if (cfg_we) start_beat = cfg_initial_beat_ms;
      if (in_valid && in_ready) begin
        if (score_err == ERR_NONE)
          parse_word(in_token_chars, in_token_length, in_begin_beats, in_length_beats,
                     int'(in_command_value));
        if (in_last_command) flush_score();
      end
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          report("unexpected word", out_event_time_ms, '0);
        end else begin
          want = pending_events.pop_front();
          if (out_event_time_ms !== want.t) report("time", out_event_time_ms, want.t);
          if (out_event_kind !== want.kind) report("kind", out_event_kind, want.kind);
          if (out_note_key !== want.key) report("key", out_note_key, want.key);
          if (out_event_amount !== want.amt) report("amount", out_event_amount, want.amt);
          if (out_event_present !== want.present)
            report("present", out_event_present, want.present);
          if (out_error_code !== want.err) report("error", out_error_code, want.err);
          if (out_last_result !== want.last) report("last", out_last_result, want.last);
        end
      end
    end
  end

endmodule

FILE: verif/tb_numbered_score_to_midi_events.sv
// Testbench top that drives score words into the block and gives the verdict.
`timescale 1ns / 1ps
module tb_numbered_score_to_midi_events;
  import nsme_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int TokNote = 0;
  localparam int TokKey = 1;
  localparam int TokTempo = 2;
  localparam int TokRest = 3;
  localparam int TokJunk = 4;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [14:0]        cfg_initial_beat_ms;
  logic               in_valid;
  logic               in_ready;
  logic [63:0]        in_token_chars;
  logic [3:0]         in_token_length;
  logic [31:0]        in_begin_beats;
  logic [31:0]        in_length_beats;
  logic signed [15:0] in_command_value;
  logic               in_last_command;
  logic               out_valid;
  logic               out_ready;
  logic [47:0]        out_event_time_ms;
  logic [1:0]         out_event_kind;
  logic signed [7:0]  out_note_key;
  logic signed [15:0] out_event_amount;
  logic               out_event_present;
  logic [1:0]         out_error_code;
  logic               out_last_result;
  int                 fails;
  int                 outstanding;
  int                 cycles;
  int                 in_idle;
  int                 out_idle;
  logic               hold_off;

  numbered_score_to_midi_events u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_initial_beat_ms(cfg_initial_beat_ms),
    .in_valid(in_valid), .in_ready(in_ready), .in_token_chars(in_token_chars),
    .in_token_length(in_token_length), .in_begin_beats(in_begin_beats),
    .in_length_beats(in_length_beats), .in_command_value(in_command_value),
    .in_last_command(in_last_command), .out_valid(out_valid), .out_ready(out_ready),
    .out_event_time_ms(out_event_time_ms), .out_event_kind(out_event_kind),
    .out_note_key(out_note_key), .out_event_amount(out_event_amount),
    .out_event_present(out_event_present), .out_error_code(out_error_code),
    .out_last_result(out_last_result)
  );

  score_event_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("numbered_score_to_midi_events regression: fail");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= hold_off ? 1'b0 : ($urandom_range(99) >= out_idle);

  function automatic logic [63:0] text_of(input string s);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 8; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  task automatic send_word(input logic [63:0] ch, input logic [3:0] len,
                           input logic [31:0] bg, input logic [31:0] dur,
                           input logic [15:0] val, input logic last);
    while ($urandom_range(99) < in_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_token_chars <= ch;
    in_token_length <= len;
    in_begin_beats <= bg;
    in_length_beats <= dur;
    in_command_value <= val;
    in_last_command <= last;
    in_valid <= 1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(negedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_beat(input logic [14:0] v);
    drain();
    cfg_we <= 1;
    cfg_initial_beat_ms <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic make_token(input int kind, output logic [63:0] ch, output logic [3:0] len);
    int n;
    int marks;
    bit up;
    ch = {$urandom, $urandom};
    case (kind)
      TokNote: begin
        ch[7:0] = 8'("1" + $urandom_range(6));
        n = 1;
        if ($urandom_range(1)) begin
          ch[15:8] = "#";
          n = 2;
        end
        marks = ($urandom_range(3) == 0) ? $urandom_range(8 - n) : $urandom_range(2);
        up = $urandom_range(1);
        for (int i = 0; i < marks; i++) begin
          if ($urandom_range(3) == 0) up = !up;
          ch[8*n +: 8] = up ? "+" : "-";
          n++;
        end
        len = 4'(n);
      end
      TokKey: begin
        ch[7:0] = 8'(($urandom_range(1) ? "A" : "a") + $urandom_range(6));
        len = 4'($urandom_range(1, 2));
        ch[15:8] = $urandom_range(1) ? "+" : "-";
      end
      TokTempo: begin
        ch[7:0] = "S";
        len = 1;
      end
      TokRest: begin
        ch[7:0] = "0";
        len = 4'($urandom_range(0, 15));
      end
      default: len = 4'($urandom_range(1, 15));
    endcase
  endtask

  task automatic play_score(input int words, input bit noisy, input bit notes_only);
    logic [63:0] ch;
    logic [3:0]  len;
    logic [31:0] bg;
    logic [31:0] dur;
    int          pick;
    int          kind;
    for (int i = 0; i < words; i++) begin
      pick = $urandom_range(99);
      if (notes_only) kind = TokNote;
      else if (pick < 50) kind = TokNote;
      else if (pick < 62) kind = TokKey;
      else if (pick < 74) kind = TokTempo;
      else if (pick < 86 || !noisy) kind = TokRest;
      else kind = TokJunk;
      make_token(kind, ch, len);
      bg = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 32'h0008_0000);
      dur = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
      send_word(ch, len, bg, dur, 16'($urandom), i == words - 1);
    end
  endtask

  task automatic random_phase(input int scores);
    for (int s = 0; s < scores; s++) play_score($urandom_range(1, 8), $urandom_range(3) == 0, 0);
  endtask

  initial begin
    cycles = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_initial_beat_ms = '0;
    in_valid = 0;
    in_token_chars = '0;
    in_token_length = '0;
    in_begin_beats = '0;
    in_length_beats = '0;
    in_command_value = '0;
    in_last_command = 0;
    hold_off = 0;
    in_idle = 0;
    out_idle = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_word(text_of("S"), 1, 32'h0001_0000, 0, 16'sd0, 0);
    send_word(text_of("S"), 1, 32'h0002_8000, 0, 16'h8000, 0);
    send_word(text_of("S"), 1, 32'hFFFF_FFFF, 0, 16'sd500, 0);
    send_word(text_of("C"), 1, 32'h0003_0000, 0, 16'sd0, 0);
    send_word(text_of("d+"), 2, 32'h0003_0000, 0, 16'sd0, 0);
    send_word(text_of("G-"), 2, 32'h0004_0000, 0, 16'sd0, 0);
    send_word(text_of("1"), 1, 32'h0004_0000, 32'hFFFF_FFFF, 16'h7FFF, 0);
    send_word(text_of("7#++++++"), 8, 32'h0005_0000, 32'h0001_0000, 16'sd64, 0);
    send_word(text_of("1-------"), 8, 32'h0005_0000, 32'h0000_8000, -16'sd5, 0);
    send_word(text_of("3#"), 2, 0, 0, 16'sd0, 0);
    send_word(text_of("0x"), 2, 0, 0, 16'sd1, 0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 0, 32'h0001_0000, 0, 16'sd1, 1);
    send_word(text_of("9"), 1, 0, 0, 16'sd1, 0);
    send_word(text_of("1"), 1, 0, 0, 16'sd1, 1);
    send_word(text_of("1#-x"), 4, 0, 0, 16'sd1, 1);
    send_word(0, 0, 0, 0, 16'sd0, 1);
    send_word(text_of("1++++++++"), 4'd12, 32'h0001_0000, 32'h0001_0000, 16'sd90, 1);
    send_word(text_of("b-"), 2, 0, 0, 16'sd0, 0);
    send_word(text_of("2"), 1, 0, 0, 16'sd200, 1);

    write_beat(15'd1);
    play_score(1, 0, 0);
    in_idle = 29;
    out_idle = 63;
    random_phase(2);

    write_beat(15'd32767);
    play_score(1, 0, 0);
    in_idle = 63;
    out_idle = 29;
    random_phase(2);

    write_beat(15'd0);
    play_score(1, 0, 0);
    in_idle = 0;
    out_idle = 0;
    play_score(2, 0, 0);
    hold_off <= 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off <= 0;
      end
    join_none
    play_score(3, 0, 0);
    play_score(3, 0, 0);
    drain();

    write_beat(15'($urandom_range(1, 32767)));
    play_score(1, 0, 0);
    play_score(32, 0, 1);
    play_score(33, 0, 1);

    drain();
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("numbered_score_to_midi_events regression: pass");
    end else begin
      $display("numbered_score_to_midi_events regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/nsme_pkg.sv
rtl/nsme_datapath.sv
rtl/nsme_ctrl.sv
rtl/numbered_score_to_midi_events.sv
verif/score_event_checker.sv
verif/tb_numbered_score_to_midi_events.sv
